// ===== design/clp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_pkg
// Shared types and constants for the CIP logical path parser: segment type
// codes, parse phases, target kinds and result status codes.
// ----------------------------------------------------------------------------
package clp_pkg;

   // segment type bytes
   localparam logic [7:0] SEG_CLASS_8  = 8'h20;
   localparam logic [7:0] SEG_CLASS_16 = 8'h21;
   localparam logic [7:0] SEG_CLASS_32 = 8'h22;
   localparam logic [7:0] SEG_INST_8   = 8'h24;
   localparam logic [7:0] SEG_INST_16  = 8'h25;
   localparam logic [7:0] SEG_INST_32  = 8'h26;
   localparam logic [7:0] SEG_ATTR_8   = 8'h30;
   localparam logic [7:0] SEG_ATTR_16  = 8'h31;

   // value byte counts per segment form
   localparam logic [2:0] LEN_8  = 3'd1;
   localparam logic [2:0] LEN_16 = 3'd2;
   localparam logic [2:0] LEN_32 = 3'd4;

   // parse phase
   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_PAD  = 2'd1,
      PH_DATA = 2'd2,
      PH_ERR  = 2'd3
   } phase_type;

   // which id a segment updates
   typedef enum logic [1:0] {
      KIND_CLASS = 2'd0,
      KIND_INST  = 2'd1,
      KIND_ATTR  = 2'd2
   } kind_type;

   // result status, also used as the latched error code
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_UNKNOWN = 2'd1,
      STATUS_TRUNC   = 2'd2,
      STATUS_MISSING = 2'd3
   } status_type;

   // seen flag bit positions
   localparam int SEEN_CLASS = 0;
   localparam int SEEN_INST  = 1;
   localparam int SEEN_ATTR  = 2;

endpackage

// ===== design/clp_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_req_if
// Byte channel into the parser: one path byte and its last-byte flag.
// ----------------------------------------------------------------------------
interface clp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] path_byte;
   logic       final_byte;

   modport source (output valid, output path_byte, output final_byte, input ready);
   modport sink   (input valid, input path_byte, input final_byte, output ready);
endinterface

// ===== design/clp_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clp_rsp_if
// Result channel out of the parser: decoded ids, presence flags and status.
// ----------------------------------------------------------------------------
interface clp_rsp_if;
   logic        valid;
   logic        ready;
   logic        path_ok;
   logic [1:0]  status;
   logic [31:0] class_value;
   logic [31:0] inst_value;
   logic [15:0] attr_id;
   logic        class_seen;
   logic        inst_seen;
   logic        attr_seen;

   modport source (output valid, output path_ok, output status, output class_value,
                   output inst_value, output attr_id, output class_seen,
                   output inst_seen, output attr_seen, input ready);
   modport sink   (input valid, input path_ok, input status, input class_value,
                   input inst_value, input attr_id, input class_seen,
                   input inst_seen, input attr_seen, output ready);
endinterface

// ===== design/cip_logical_path_parser.sv =====
`timescale 1ns / 1ps
// The result is registered and appears in the cycle after a path's final byte is accepted.
// Throughput: one byte per cycle; the byte update is a single register-to-register step.
// The input stalls only while a result is held and not taken; a result taken in a cycle
// lets a byte enter in that same cycle.
// Reset (synchronous, active high) clears the parse state, the ids, the flags and rsp valid.
// ----------------------------------------------------------------------------
// cip_logical_path_parser
// Parses a CIP logical path one byte at a time and gives one result per path
// with the class, instance and attribute ids, presence flags and a status.
// ----------------------------------------------------------------------------
module cip_logical_path_parser
   import clp_pkg::*;
(
   input logic       clock,
   input logic       reset,
   clp_req_if.sink   req,
   clp_rsp_if.source rsp
);

   // parse state
   phase_type   phase_ff,   phase_in;
   kind_type    kind_ff,    kind_in;
   logic [2:0]  left_ff,    left_in;
   logic [1:0]  pos_ff,     pos_in;
   logic [31:0] accum_ff,   accum_in;
   logic [31:0] class_ff,   class_in;
   logic [31:0] inst_ff,    inst_in;
   logic [15:0] attr_ff,    attr_in;
   logic [2:0]  seen_ff,    seen_in;
   status_type  err_ff,     err_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_class_ff, rsp_class_in;
   logic [31:0] rsp_inst_ff,  rsp_inst_in;
   logic [15:0] rsp_attr_ff,  rsp_attr_in;
   logic [2:0]  rsp_seen_ff,  rsp_seen_in;

   logic        req_accept;
   logic        seg_known;
   kind_type    seg_kind;
   logic [2:0]  seg_len;
   logic [31:0] byte_shifted;
   status_type  status_calc;

   // input side stalls only when a result is held and not taken
   assign req.ready  = !rsp_valid_ff || rsp.ready;
   assign req_accept = req.valid && req.ready;

   // segment type decode
   always_comb begin
      seg_known = 1'b1;
      seg_kind  = KIND_CLASS;
      seg_len   = LEN_8;
      unique case (req.path_byte)
         SEG_CLASS_8:  begin seg_kind = KIND_CLASS; seg_len = LEN_8;  end
         SEG_CLASS_16: begin seg_kind = KIND_CLASS; seg_len = LEN_16; end
         SEG_CLASS_32: begin seg_kind = KIND_CLASS; seg_len = LEN_32; end
         SEG_INST_8:   begin seg_kind = KIND_INST;  seg_len = LEN_8;  end
         SEG_INST_16:  begin seg_kind = KIND_INST;  seg_len = LEN_16; end
         SEG_INST_32:  begin seg_kind = KIND_INST;  seg_len = LEN_32; end
         SEG_ATTR_8:   begin seg_kind = KIND_ATTR;  seg_len = LEN_8;  end
         SEG_ATTR_16:  begin seg_kind = KIND_ATTR;  seg_len = LEN_16; end
         default:      seg_known = 1'b0;
      endcase
   end

   // little-endian placement of a value byte
   assign byte_shifted = {24'd0, req.path_byte} << {pos_ff, 3'b000};

   // next state and result
   always_comb begin
      phase_in      = phase_ff;
      kind_in       = kind_ff;
      left_in       = left_ff;
      pos_in        = pos_ff;
      accum_in      = accum_ff;
      class_in      = class_ff;
      inst_in       = inst_ff;
      attr_in       = attr_ff;
      seen_in       = seen_ff;
      err_in        = err_ff;
      status_calc   = STATUS_OK;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_class_in  = rsp_class_ff;
      rsp_inst_in   = rsp_inst_ff;
      rsp_attr_in   = rsp_attr_ff;
      rsp_seen_in   = rsp_seen_ff;

      if (req_accept) begin
         // byte update
         unique case (phase_ff)
            PH_TYPE: begin
               if (seg_known) begin
                  kind_in  = seg_kind;
                  left_in  = seg_len;
                  pos_in   = 2'd0;
                  accum_in = 32'd0;
                  phase_in = (seg_len > LEN_8) ? PH_PAD : PH_DATA;
               end else begin
                  err_in   = STATUS_UNKNOWN;
                  phase_in = PH_ERR;
               end
            end
            PH_PAD: phase_in = PH_DATA;
            PH_DATA: begin
               accum_in = accum_ff | byte_shifted;
               pos_in   = pos_ff + 2'd1;
               left_in  = left_ff - 3'd1;
               if (left_in == 3'd0) begin
                  phase_in = PH_TYPE;
                  unique case (kind_ff)
                     KIND_CLASS: begin
                        class_in            = accum_in;
                        seen_in[SEEN_CLASS] = 1'b1;
                     end
                     KIND_INST: begin
                        inst_in            = accum_in;
                        seen_in[SEEN_INST] = 1'b1;
                     end
                     default: begin
                        attr_in            = accum_in[15:0];
                        seen_in[SEEN_ATTR] = 1'b1;
                     end
                  endcase
               end
            end
            default: ;
         endcase

         // end of path: build the result and start over
         if (req.final_byte) begin
            if (err_in == STATUS_OK && phase_in != PH_TYPE) begin
               err_in = STATUS_TRUNC;
            end
            priority if (err_in != STATUS_OK) begin
               status_calc = err_in;
            end else if (!(seen_in[SEEN_CLASS] && seen_in[SEEN_INST])) begin
               status_calc = STATUS_MISSING;
            end else begin
               status_calc = STATUS_OK;
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_calc;
            rsp_class_in  = class_in;
            rsp_inst_in   = inst_in;
            rsp_attr_in   = attr_in;
            rsp_seen_in   = seen_in;

            phase_in = PH_TYPE;
            kind_in  = KIND_CLASS;
            left_in  = 3'd0;
            pos_in   = 2'd0;
            accum_in = 32'd0;
            class_in = 32'd0;
            inst_in  = 32'd0;
            attr_in  = 16'd0;
            seen_in  = 3'd0;
            err_in   = STATUS_OK;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         kind_ff      <= KIND_CLASS;
         left_ff      <= 3'd0;
         pos_ff       <= 2'd0;
         accum_ff     <= 32'd0;
         class_ff     <= 32'd0;
         inst_ff      <= 32'd0;
         attr_ff      <= 16'd0;
         seen_ff      <= 3'd0;
         err_ff       <= STATUS_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         left_ff      <= left_in;
         pos_ff       <= pos_in;
         accum_ff     <= accum_in;
         class_ff     <= class_in;
         inst_ff      <= inst_in;
         attr_ff      <= attr_in;
         seen_ff      <= seen_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_inst_ff   <= rsp_inst_in;
      rsp_attr_ff   <= rsp_attr_in;
      rsp_seen_ff   <= rsp_seen_in;
   end

   // result outputs
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.path_ok     = (rsp_status_ff == STATUS_OK);
   assign rsp.status      = rsp_status_ff;
   assign rsp.class_value = rsp_class_ff;
   assign rsp.inst_value  = rsp_inst_ff;
   assign rsp.attr_id     = rsp_attr_ff;
   assign rsp.class_seen  = rsp_seen_ff[SEEN_CLASS];
   assign rsp.inst_seen   = rsp_seen_ff[SEEN_INST];
   assign rsp.attr_seen   = rsp_seen_ff[SEEN_ATTR];

   // a final byte always produces a result next cycle
   a_final_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept && req.final_byte |=> rsp_valid_ff)
      else $error("final byte accepted but no result raised");

   // parse state is back to start after a final byte
   a_final_restarts: assert property (@(posedge clock) disable iff (reset)
      req_accept && req.final_byte |=> phase_ff == PH_TYPE && err_ff == STATUS_OK
         && seen_ff == 3'd0)
      else $error("parse state not cleared after final byte");

   // error phase only with an unknown segment latched
   a_err_phase_code: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERR |-> err_ff == STATUS_UNKNOWN)
      else $error("error phase without unknown segment code");

   // a clean result always carries class and instance
   a_ok_has_ids: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == STATUS_OK
         |-> rsp_seen_ff[SEEN_CLASS] && rsp_seen_ff[SEEN_INST])
      else $error("ok status without class and instance");

   // value bytes are counted only while collecting
   a_data_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> left_ff != 3'd0)
      else $error("collecting with no value bytes left");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the CIP logical path parser. Byte streams made of
// class, instance and attribute segments of every width are sent, some of
// them cut short or broken by unknown type bytes, while both handshakes
// stall at random. A behavioral parser predicts each path result, and every
// result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_top
   import clp_pkg::*;
();

   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_BYTES  = 400;
   localparam int MAX_REPORTS  = 40;

   // type bytes that match no segment form
   localparam logic [7:0] SEG_BAD_LOW  = 8'h00;
   localparam logic [7:0] SEG_BAD_HIGH = 8'hFF;

   localparam logic [7:0] SEG_CODES [8] = '{SEG_CLASS_8, SEG_CLASS_16, SEG_CLASS_32,
                                            SEG_INST_8, SEG_INST_16, SEG_INST_32,
                                            SEG_ATTR_8, SEG_ATTR_16};

   typedef struct packed {
      logic        path_ok;
      status_type  status;
      logic [31:0] class_value;
      logic [31:0] inst_value;
      logic [15:0] attr_id;
      logic        class_seen;
      logic        inst_seen;
      logic        attr_seen;
   } path_result_type;

   logic clock;
   logic reset;

   clp_req_if req_ch ();
   clp_rsp_if rsp_ch ();

   cip_logical_path_parser dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // predicted parser state
   phase_type   prs_phase;
   kind_type    prs_kind;
   logic [2:0]  prs_left;
   logic [1:0]  prs_pos;
   logic [31:0] prs_accum;
   logic [31:0] prs_class;
   logic [31:0] prs_inst;
   logic [15:0] prs_attr;
   logic [2:0]  prs_seen;
   status_type  prs_err;

   path_result_type expected_results [$];
   logic [7:0]      path_bytes [$];

   int src_idle_pct  = 0;
   int sink_idle_pct = 0;
   int hold_len      = 0;
   int hold_id       = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int stall_cycles  = 0;

   int unsigned n_bytes   = 0;
   int unsigned n_paths   = 0;
   int unsigned n_results = 0;
   int unsigned n_fail    = 0;
   int unsigned status_count [4] = '{0, 0, 0, 0};

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic void clear_parser();
      prs_phase = PH_TYPE;
      prs_kind  = KIND_CLASS;
      prs_left  = '0;
      prs_pos   = '0;
      prs_accum = '0;
      prs_class = '0;
      prs_inst  = '0;
      prs_attr  = '0;
      prs_seen  = '0;
      prs_err   = STATUS_OK;
   endfunction

   function automatic void open_segment(input kind_type kind, input logic [2:0] len);
      prs_kind  = kind;
      prs_left  = len;
      prs_pos   = '0;
      prs_accum = '0;
      prs_phase = (len > 3'd1) ? PH_PAD : PH_DATA;
   endfunction

   // advance on one byte; returns 1 with the path result on a final byte
   function automatic bit parse_byte(input logic [7:0] b, input logic fin,
                                     output path_result_type res);
      status_type st;
      res = '0;
      case (prs_phase)
         PH_TYPE: begin
            case (b)
               SEG_CLASS_8:  open_segment(KIND_CLASS, LEN_8);
               SEG_CLASS_16: open_segment(KIND_CLASS, LEN_16);
               SEG_CLASS_32: open_segment(KIND_CLASS, LEN_32);
               SEG_INST_8:   open_segment(KIND_INST, LEN_8);
               SEG_INST_16:  open_segment(KIND_INST, LEN_16);
               SEG_INST_32:  open_segment(KIND_INST, LEN_32);
               SEG_ATTR_8:   open_segment(KIND_ATTR, LEN_8);
               SEG_ATTR_16:  open_segment(KIND_ATTR, LEN_16);
               default: begin
                  prs_err   = STATUS_UNKNOWN;
                  prs_phase = PH_ERR;
               end
            endcase
         end
         PH_PAD: prs_phase = PH_DATA;
         PH_DATA: begin
            // little-endian assembly, commit on the last value byte
            prs_accum = prs_accum | ({24'd0, b} << (8 * prs_pos));
            prs_pos   = prs_pos + 2'd1;
            prs_left  = prs_left - 3'd1;
            if (prs_left == 3'd0) begin
               case (prs_kind)
                  KIND_CLASS: begin
                     prs_class = prs_accum;
                     prs_seen[SEEN_CLASS] = 1'b1;
                  end
                  KIND_INST: begin
                     prs_inst = prs_accum;
                     prs_seen[SEEN_INST] = 1'b1;
                  end
                  default: begin
                     prs_attr = prs_accum[15:0];
                     prs_seen[SEEN_ATTR] = 1'b1;
                  end
               endcase
               prs_phase = PH_TYPE;
            end
         end
         default: ;
      endcase

      if (!fin) return 1'b0;

      // a path ending mid-segment is truncated; a latched error wins
      if (prs_err == STATUS_OK && prs_phase != PH_TYPE) prs_err = STATUS_TRUNC;
      if (prs_err != STATUS_OK) st = prs_err;
      else if (!(prs_seen[SEEN_CLASS] && prs_seen[SEEN_INST])) st = STATUS_MISSING;
      else st = STATUS_OK;

      res.path_ok     = (st == STATUS_OK);
      res.status      = st;
      res.class_value = prs_class;
      res.inst_value  = prs_inst;
      res.attr_id     = prs_attr;
      res.class_seen  = prs_seen[SEEN_CLASS];
      res.inst_seen   = prs_seen[SEEN_INST];
      res.attr_seen   = prs_seen[SEEN_ATTR];
      clear_parser();
      return 1'b1;
   endfunction

   initial clear_parser();

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want != got) begin
         if (n_fail < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         n_fail++;
      end
   endfunction

   function automatic void check_result();
      path_result_type want;
      if (expected_results.size() == 0) begin
         if (n_fail < MAX_REPORTS)
            $display("%0t: result with none expected, got status %0d", $time,
                     rsp_ch.status);
         n_fail++;
         return;
      end
      want = expected_results.pop_front();
      n_results++;
      status_count[want.status]++;
      check_field("path_ok",     want.path_ok,     rsp_ch.path_ok);
      check_field("status",      want.status,      rsp_ch.status);
      check_field("class_value", want.class_value, rsp_ch.class_value);
      check_field("inst_value",  want.inst_value,  rsp_ch.inst_value);
      check_field("attr_id",     want.attr_id,     rsp_ch.attr_id);
      check_field("class_seen",  want.class_seen,  rsp_ch.class_seen);
      check_field("inst_seen",   want.inst_seen,   rsp_ch.inst_seen);
      check_field("attr_seen",   want.attr_seen,   rsp_ch.attr_seen);
   endfunction

   // predict on accepted bytes, compare on accepted results
   always @(posedge clock) begin : monitor
      path_result_type res;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            if (parse_byte(req_ch.path_byte, req_ch.final_byte, res))
               expected_results.push_back(res);
         end
         if (rsp_ch.valid && rsp_ch.ready) check_result();
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_id != hold_seen) begin
         hold_seen = hold_id;
         hold_left = hold_len - 1;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
   end

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.path_byte  <= b;
      req_ch.final_byte <= fin;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n_bytes++;
   endtask

   task automatic send_path();
      for (int i = 0; i < path_bytes.size(); i++)
         send_byte(path_bytes[i], i == path_bytes.size() - 1);
      n_paths++;
   endtask

   // lower valid and wait until every predicted result has been taken
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_byte();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 8'h00;
      if (pick == 1) return 8'hFF;
      return 8'($urandom_range(255));
   endfunction

   function automatic void append_segment(input logic [7:0] code);
      logic [2:0] len;
      case (code)
         SEG_CLASS_16, SEG_INST_16, SEG_ATTR_16: len = LEN_16;
         SEG_CLASS_32, SEG_INST_32:              len = LEN_32;
         default:                                len = LEN_8;
      endcase
      path_bytes.push_back(code);
      if (len > LEN_8) path_bytes.push_back(rand_byte());
      for (int i = 0; i < len; i++) path_bytes.push_back(rand_byte());
   endfunction

   // mostly well-formed paths, the rest cut short or with a random type byte and noise
   function automatic void build_random_path();
      int kind;
      int nseg;
      int cls_at;
      int inst_at;
      int cut;
      logic [7:0] code;
      path_bytes.delete();
      kind    = $urandom_range(99);
      nseg    = $urandom_range(2, 5);
      cls_at  = $urandom_range(nseg - 1);
      inst_at = (cls_at + $urandom_range(1, nseg - 1)) % nseg;
      if (kind < 85) begin
         for (int i = 0; i < nseg; i++) begin
            code = SEG_CODES[$urandom_range(7)];
            if ($urandom_range(99) < 80) begin
               if (i == cls_at) code = SEG_CODES[$urandom_range(2)];
               if (i == inst_at) code = SEG_CODES[$urandom_range(5, 3)];
            end
            append_segment(code);
         end
         if (kind >= 70) begin
            // truncated tail segment
            cut = path_bytes.size();
            append_segment(SEG_CODES[$urandom_range(7)]);
            cut = $urandom_range(path_bytes.size() - 1, cut + 1);
            while (path_bytes.size() > cut) void'(path_bytes.pop_back());
         end
      end else begin
         // prefix, then a random type byte and noise
         for (int i = 0; i < $urandom_range(2); i++)
            append_segment(SEG_CODES[$urandom_range(7)]);
         path_bytes.push_back(8'($urandom_range(255)));
         for (int i = 0; i < $urandom_range(4); i++)
            path_bytes.push_back(8'($urandom_range(255)));
      end
   endfunction

   task automatic set_idle(input int src_pct, input int sink_pct);
      src_idle_pct  = src_pct;
      sink_idle_pct = sink_pct;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_directed_paths();
      // 8-bit class and instance at value extremes
      path_bytes = '{SEG_CLASS_8, 8'hFF, SEG_INST_8, 8'h00};
      send_path();
      // 32-bit class all ones after a zero pad, 16-bit instance zero after an all-ones pad
      path_bytes = '{SEG_CLASS_32, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     SEG_INST_16, 8'hFF, 8'h00, 8'h00};
      send_path();
      // attribute alone, class and instance missing
      path_bytes = '{SEG_ATTR_8, 8'h01};
      send_path();
      // later class overwrites the earlier one, instance missing
      path_bytes = '{SEG_CLASS_8, 8'h05, SEG_CLASS_8, 8'h07};
      send_path();
      // unknown type byte as the only byte
      path_bytes = '{SEG_BAD_HIGH};
      send_path();
      // unknown type byte after complete segments, later bytes ignored
      path_bytes = '{SEG_CLASS_8, 8'h09, SEG_INST_8, 8'h01, SEG_BAD_LOW, SEG_CLASS_8};
      send_path();
      // path ends on the pad byte's turn
      path_bytes = '{SEG_CLASS_16};
      send_path();
      // path ends inside a 16-bit attribute value
      path_bytes = '{SEG_ATTR_16, 8'h00, 8'h34};
      send_path();
   endtask

   task automatic test_random_paths(input int byte_budget);
      int unsigned start;
      start = n_bytes;
      while (n_bytes - start < byte_budget) begin
         build_random_path();
         send_path();
      end
   endtask

   // receiver holds off while short paths keep coming, so the input stalls
   task automatic test_result_backpressure();
      set_idle(0, 0);
      hold_len = HOLD_CYCLES;
      hold_id  = hold_id + 1;
      for (int i = 0; i < 6; i++) begin
         path_bytes = '{SEG_CLASS_8, rand_byte(), SEG_INST_8, rand_byte()};
         send_path();
      end
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.path_byte  <= '0;
      req_ch.final_byte <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      set_idle(19, 84);
      test_directed_paths();
      test_random_paths(PHASE_BYTES);
      wait_drained();

      test_result_backpressure();

      set_idle(84, 19);
      test_random_paths(PHASE_BYTES);
      wait_drained();

      set_idle(0, 0);
      test_random_paths(PHASE_BYTES);
      wait_drained();

      // let any stray result show up
      repeat (20) @(posedge clock);

      $display("covered %0d bytes in %0d paths, %0d results checked", n_bytes, n_paths,
               n_results);
      $display("results by status: ok %0d, unknown %0d, truncated %0d, missing %0d",
               status_count[STATUS_OK], status_count[STATUS_UNKNOWN],
               status_count[STATUS_TRUNC], status_count[STATUS_MISSING]);
      if (n_fail == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
